// ===== rtl/q2e_pkg.sv =====
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared widths, pipeline word types and constants of the quaternion to
// Euler angle converter.
// ----------------------------------------------------------------------------
package q2e_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_LEN         = 24;
  localparam int SQRT_STEPS       = 32;
  localparam int ARGW             = 35;
  localparam int XW               = 52;
  localparam int ZW               = 35;
  localparam int PW               = 37;
  localparam int OW               = 16;

  localparam logic signed [ZW-1:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [PW-1:0] HALF_PI_Q30 = 37'sd1686629713;
  localparam logic signed [ARGW-1:0] ONE_Q30   = 35'sd1073741824;
  localparam int ANG_MAX   = 25736;
  localparam int PITCH_MAX = 12868;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] root;
  } sqrt_lane_t;

  typedef struct packed {
    logic                   v;
    sqrt_lane_t             sp;
    sqrt_lane_t             cp;
    logic signed [ARGW-1:0] sr;
    logic signed [ARGW-1:0] cr;
    logic signed [ARGW-1:0] sy;
    logic signed [ARGW-1:0] cy;
  } sqrt_word_t;

  typedef struct packed {
    logic                 zero;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_lane_t;

  typedef struct packed {
    logic               v;
    cordic_lane_t [2:0] lane;
  } cordic_word_t;

  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] a;
    unique case (i)
      0:  a = 35'sd843314857;
      1:  a = 35'sd497837829;
      2:  a = 35'sd263043837;
      3:  a = 35'sd133525159;
      4:  a = 35'sd67021687;
      5:  a = 35'sd33543516;
      6:  a = 35'sd16775851;
      7:  a = 35'sd8388437;
      8:  a = 35'sd4194283;
      9:  a = 35'sd2097149;
      10: a = 35'sd1048576;
      11: a = 35'sd524288;
      12: a = 35'sd262144;
      13: a = 35'sd131072;
      14: a = 35'sd65536;
      15: a = 35'sd32768;
      16: a = 35'sd16384;
      17: a = 35'sd8192;
      18: a = 35'sd4096;
      19: a = 35'sd2048;
      20: a = 35'sd1024;
      21: a = 35'sd512;
      22: a = 35'sd256;
      23: a = 35'sd128;
      default: a = '0;
    endcase
    return a;
  endfunction

  function automatic logic signed [OW-1:0] to_q13(input logic signed [PW-1:0] z,
                                                  input int lim);
    logic signed [PW-1:0] r;
    logic signed [PW-1:0] l;
    r = (z + PW'(65536)) >>> 17;
    l = PW'(lim);
    if (r > l) r = l;
    if (r < -l) r = -l;
    return r[OW-1:0];
  endfunction

endpackage

// ===== rtl/q2e_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// q2e_sqrt_cell
// One restoring square-root digit for both pitch radicands; carries the
// roll and yaw arguments along.
// ----------------------------------------------------------------------------
module q2e_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  q2e_pkg::sqrt_word_t  d,
  output q2e_pkg::sqrt_word_t  q
);
  import q2e_pkg::*;

  localparam logic [63:0] BIT = 64'(1) << (62 - 2 * STEP);

  sqrt_word_t nxt;

  function automatic sqrt_lane_t digit(input sqrt_lane_t s);
    sqrt_lane_t o;
    logic [63:0] trial;
    trial = s.root + BIT;
    if (s.rem >= trial) begin
      o.rem  = s.rem - trial;
      o.root = (s.root >> 1) + BIT;
    end else begin
      o.rem  = s.rem;
      o.root = s.root >> 1;
    end
    return o;
  endfunction

  always_comb begin
    nxt    = d;
    nxt.sp = digit(d.sp);
    nxt.cp = digit(d.cp);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.v <= 1'b0;
    end else if (en) begin
      q <= nxt;
    end
  end

endmodule

// ===== rtl/q2e_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// q2e_cordic_cell
// One vectoring CORDIC micro-rotation for the roll, pitch and yaw lanes.
// ----------------------------------------------------------------------------
module q2e_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  q2e_pkg::cordic_word_t d,
  output q2e_pkg::cordic_word_t q
);
  import q2e_pkg::*;

  localparam logic signed [ZW-1:0] ANG = atan_q30(STEP);

  cordic_word_t nxt;

  always_comb begin
    nxt = d;
    for (int k = 0; k < 3; k++) begin
      if (d.lane[k].y > 0) begin
        nxt.lane[k].x = d.lane[k].x + (d.lane[k].y >>> STEP);
        nxt.lane[k].y = d.lane[k].y - (d.lane[k].x >>> STEP);
        nxt.lane[k].z = d.lane[k].z + ANG;
      end else begin
        nxt.lane[k].x = d.lane[k].x - (d.lane[k].y >>> STEP);
        nxt.lane[k].y = d.lane[k].y + (d.lane[k].x >>> STEP);
        nxt.lane[k].z = d.lane[k].z - ANG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.v <= 1'b0;
    end else if (en) begin
      q <= nxt;
    end
  end

endmodule

// ===== rtl/quaternion_to_euler_unit.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_euler_unit
// Unit quaternion (Q1.15) to roll and yaw (Q3.13) and pitch (Q2.13) in radians.
// ----------------------------------------------------------------------------
// Input word qw/qx/qy/qz moves on in_valid/in_ready; the angle word
// roll/pitch/yaw moves on out_valid/out_ready.
// The datapath is a row of cells: one product stage, one sum stage, 32
// square-root digit cells, one quadrant stage, CORDIC_STEPS rotation cells
// (capped at 24) and an output register. One word is taken every cycle
// unless the row holds. All cells advance together. While an output word
// waits and out_ready is low the whole row holds and in_ready is low;
// empty slots in the row do not hold it. Reset clears every valid bit; no
// words are in flight after.
// ----------------------------------------------------------------------------
module quaternion_to_euler_unit #(
  parameter int CORDIC_STEPS = q2e_pkg::CORDIC_STEPS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [15:0]        qw,
  input  logic signed [15:0]        qx,
  input  logic signed [15:0]        qy,
  input  logic signed [15:0]        qz,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [15:0]        roll,
  output logic signed [14:0]        pitch,
  output logic signed [15:0]        yaw
);
  import q2e_pkg::*;

  localparam int NSTEPS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // product stage
  logic               a_v;
  logic signed [31:0] p_wx, p_yz, p_xx, p_yy, p_wz, p_xy, p_zz, p_wy, p_xz;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v  <= in_valid;
      p_wx <= 32'(qw) * 32'(qx);
      p_yz <= 32'(qy) * 32'(qz);
      p_xx <= 32'(qx) * 32'(qx);
      p_yy <= 32'(qy) * 32'(qy);
      p_wz <= 32'(qw) * 32'(qz);
      p_xy <= 32'(qx) * 32'(qy);
      p_zz <= 32'(qz) * 32'(qz);
      p_wy <= 32'(qw) * 32'(qy);
      p_xz <= 32'(qx) * 32'(qz);
    end
  end

  // sum stage
  sqrt_word_t             sq [0:SQRT_STEPS];
  sqrt_word_t             sum_next;
  logic signed [ARGW-1:0] t, rs, rc;

  always_comb begin
    t  = ARGW'(p_wy) - ARGW'(p_xz);
    t  = t <<< 1;
    rs = ONE_Q30 + t;
    rc = ONE_Q30 - t;
    sum_next.v  = a_v;
    sum_next.sr = (ARGW'(p_wx) + ARGW'(p_yz)) <<< 1;
    sum_next.cr = ONE_Q30 - ((ARGW'(p_xx) + ARGW'(p_yy)) <<< 1);
    sum_next.sy = (ARGW'(p_wz) + ARGW'(p_xy)) <<< 1;
    sum_next.cy = ONE_Q30 - ((ARGW'(p_yy) + ARGW'(p_zz)) <<< 1);
    sum_next.sp.root = '0;
    sum_next.cp.root = '0;
    sum_next.sp.rem  = (rs < 0) ? 64'd0 : (64'(rs[ARGW-2:0]) << 30);
    sum_next.cp.rem  = (rc < 0) ? 64'd0 : (64'(rc[ARGW-2:0]) << 30);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq[0].v <= 1'b0;
    end else if (en) begin
      sq[0] <= sum_next;
    end
  end

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    q2e_sqrt_cell #(.STEP(g)) u_cell (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .d   (sq[g]),
      .q   (sq[g+1])
    );
  end

  // quadrant stage
  function automatic cordic_lane_t start_lane(input logic signed [XW-1:0] y,
                                              input logic signed [XW-1:0] x);
    cordic_lane_t l;
    l.zero = (x == 0) && (y == 0);
    l.x    = x;
    l.y    = y;
    l.z    = '0;
    if (x < 0) begin
      l.z = (y >= 0) ? PI_Q30 : -PI_Q30;
      l.x = -x;
      l.y = -y;
    end
    return l;
  endfunction

  cordic_word_t cw [0:NSTEPS];
  cordic_word_t start_next;
  sqrt_word_t   sl;

  always_comb begin
    sl = sq[SQRT_STEPS];
    start_next.v = sl.v;
    start_next.lane[0] = start_lane(XW'(sl.sr) <<< 16, XW'(sl.cr) <<< 16);
    start_next.lane[1] = start_lane(XW'({1'b0, sl.sp.root[32:0]}) <<< 16,
                                    XW'({1'b0, sl.cp.root[32:0]}) <<< 16);
    start_next.lane[2] = start_lane(XW'(sl.sy) <<< 16, XW'(sl.cy) <<< 16);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cw[0].v <= 1'b0;
    end else if (en) begin
      cw[0] <= start_next;
    end
  end

  for (genvar g = 0; g < NSTEPS; g++) begin : g_cordic
    q2e_cordic_cell #(.STEP(g)) u_cell (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .d   (cw[g]),
      .q   (cw[g+1])
    );
  end

  // output register
  logic signed [PW-1:0] z_roll, z_pitch, z_yaw;
  logic signed [OW-1:0] r_pitch;

  always_comb begin
    z_roll  = cw[NSTEPS].lane[0].zero ? PW'(0) : PW'(cw[NSTEPS].lane[0].z);
    z_yaw   = cw[NSTEPS].lane[2].zero ? PW'(0) : PW'(cw[NSTEPS].lane[2].z);
    z_pitch = cw[NSTEPS].lane[1].zero ? PW'(0) : PW'(cw[NSTEPS].lane[1].z);
    z_pitch = (z_pitch <<< 1) - HALF_PI_Q30;
    r_pitch = to_q13(z_pitch, PITCH_MAX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= cw[NSTEPS].v;
      roll      <= to_q13(z_roll, ANG_MAX);
      pitch     <= r_pitch[14:0];
      yaw       <= to_q13(z_yaw, ANG_MAX);
    end
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives quaternion words into quaternion_to_euler_unit with random gaps and
// output stalls, predicts roll, pitch and yaw with a bit-exact fixed-point
// model (CORDIC atan2, digit-by-digit square root) and checks every angle
// word in order.
// ----------------------------------------------------------------------------
module testbench;
  import q2e_pkg::*;

  localparam int STEPS      = 16;
  localparam int LATENCY    = STEPS + 36;
  localparam int N_RANDOM   = 830;
  localparam longint PI_VAL   = 64'sd3373259426;
  localparam longint HALF_PI  = 64'sd1686629713;
  localparam longint ONE_VAL  = 64'sd1073741824;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
  } angles_t;

  typedef struct {
    logic signed [15:0] w, x, y, z;
    bit                 has_fixed;
    angles_t            fixed;
  } quat_row_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic signed [15:0] qw = '0, qx = '0, qy = '0, qz = '0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [15:0] roll;
  logic signed [14:0] pitch;
  logic signed [15:0] yaw;

  angles_t   angles_due[$];
  quat_row_t dir_rows[$];
  int        errors = 0;
  bit        allow_stall = 1;

  quaternion_to_euler_unit #(.CORDIC_STEPS(STEPS)) dut (
    .clk, .rst, .in_valid, .in_ready, .qw, .qx, .qy, .qz,
    .out_valid, .out_ready, .roll, .pitch, .yaw
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  function automatic longint shr_ar(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_angle(longint ys, longint xs);
    longint xa, ya, za, dx, dy;
    za = 0;
    if (xs == 0 && ys == 0) return 0;
    xa = xs * 65536;
    ya = ys * 65536;
    if (xa < 0) begin
      za = (ya >= 0) ? PI_VAL : -PI_VAL;
      xa = -xa;
      ya = -ya;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = shr_ar(ya, i);
      dy = shr_ar(xa, i);
      if (ya > 0) begin
        xa += dx; ya -= dy; za += longint'(atan_q30(i));
      end else begin
        xa -= dx; ya += dy; za -= longint'(atan_q30(i));
      end
    end
    return za;
  endfunction

  function automatic longint root_q30(longint r);
    logic [63:0] v, rt, b;
    rt = 0;
    b = 64'd1 << 62;
    if (r <= 0) return 0;
    v = 64'(r) << 30;
    for (int i = 0; i < 32; i++) begin
      if (v >= rt + b) begin
        v -= rt + b;
        rt = (rt >> 1) + b;
      end else begin
        rt >>= 1;
      end
      b >>= 2;
    end
    return longint'(rt);
  endfunction

  function automatic longint round_q13(longint z, longint lim);
    longint r;
    r = shr_ar(z + 65536, 17);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic angles_t euler_of(logic signed [15:0] w, x, y, z);
    longint lw, lx, ly, lz, sr, cr, sy, cy, t, sp, cp;
    angles_t a;
    lw = w; lx = x; ly = y; lz = z;
    sr = 2 * (lw * lx + ly * lz);
    cr = ONE_VAL - 2 * (lx * lx + ly * ly);
    sy = 2 * (lw * lz + lx * ly);
    cy = ONE_VAL - 2 * (ly * ly + lz * lz);
    t  = 2 * (lw * ly - lx * lz);
    sp = root_q30(ONE_VAL + t);
    cp = root_q30(ONE_VAL - t);
    a.roll  = 16'(round_q13(atan_angle(sr, cr), ANG_MAX));
    a.pitch = 15'(round_q13(2 * atan_angle(sp, cp) - HALF_PI, PITCH_MAX));
    a.yaw   = 16'(round_q13(atan_angle(sy, cy), ANG_MAX));
    return a;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  task automatic send_quat(logic signed [15:0] w, x, y, z);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(negedge clk);
    end
    qw <= w; qx <= x; qy <= y; qz <= z;
    in_valid <= 1;
    angles_due.push_back(euler_of(w, x, y, z));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic void add_row(logic signed [15:0] w, x, y, z, bit fx,
                                  int r, int p, int yw);
    quat_row_t q;
    q.w = w; q.x = x; q.y = y; q.z = z; q.has_fixed = fx;
    q.fixed.roll = 16'(r); q.fixed.pitch = 15'(p); q.fixed.yaw = 16'(yw);
    dir_rows.push_back(q);
  endfunction

  // sink: stall at random, check words
  initial begin
    angles_t e;
    forever begin
      @(negedge clk);
      if (allow_stall && $urandom_range(0, 9) < 3)
        out_ready <= 0;
      else
        out_ready <= 1;
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (angles_due.size() == 0) begin
          report_mismatch("unexpected word", 0, 0);
        end else begin
          e = angles_due.pop_front();
          if (roll !== e.roll) report_mismatch("roll", roll, e.roll);
          if (pitch !== e.pitch) report_mismatch("pitch", pitch, e.pitch);
          if (yaw !== e.yaw) report_mismatch("yaw", yaw, e.yaw);
        end
      end
    end
  end

  initial begin
    int wait_cnt;
    logic signed [15:0] c[4];
    // identity and extremes
    add_row(16'sd32767, 0, 0, 0, 1, 0, 0, 0);
    add_row(0, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, 16'sd32767, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, 16'sd32767, 0, 0, 0, 0, 0);
    add_row(0, 0, 0, 16'sd32767, 0, 0, 0, 0);
    add_row(-16'sd32768, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, -16'sd32768, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, -16'sd32768, 0, 0, 0, 0, 0);
    add_row(0, 0, 0, -16'sd32768, 0, 0, 0, 0);
    add_row(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 0, 0, 0, 0);
    add_row(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 0, 0, 0, 0);
    add_row(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, 0, 0, 0, 0);
    add_row(16'sd23170, 16'sd23170, 0, 0, 0, 0, 0, 0);
    add_row(16'sd23170, 0, 16'sd23170, 0, 0, 0, 0, 0);
    add_row(16'sd23170, 0, -16'sd23170, 0, 0, 0, 0, 0);
    add_row(16'sd23170, 0, 0, 16'sd23170, 0, 0, 0, 0);
    add_row(16'sd23170, 0, 0, -16'sd23170, 0, 0, 0, 0);
    add_row(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 0, 0, 0, 0);
    add_row(16'sd16384, -16'sd16384, 16'sd16384, -16'sd16384, 0, 0, 0, 0);
    add_row(16'sd30000, 16'sd30000, 16'sd30000, 16'sd30000, 0, 0, 0, 0);
    add_row(-16'sd30000, 16'sd30000, -16'sd30000, 16'sd30000, 0, 0, 0, 0);
    add_row(16'sd1, -16'sd1, 16'sd1, -16'sd1, 0, 0, 0, 0);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    foreach (dir_rows[i]) begin
      send_quat(dir_rows[i].w, dir_rows[i].x, dir_rows[i].y, dir_rows[i].z);
      if (dir_rows[i].has_fixed) angles_due[$] = dir_rows[i].fixed;
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 2) begin
        in_valid <= 0;
        while (angles_due.size() != 0) @(posedge clk);
        @(negedge clk);
      end
      if (n >= 300 && n < 400) allow_stall = 0;
      else allow_stall = 1;
      if ($urandom_range(0, 9) < 7) begin
        // one full-scale component, the rest random
        for (int k = 0; k < 4; k++) c[k] = 16'($signed($urandom_range(0, 40000)) - 20000);
        c[$urandom_range(0, 3)] = $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
      end else begin
        for (int k = 0; k < 4; k++) c[k] = 16'($urandom);
      end
      send_quat(c[0], c[1], c[2], c[3]);
    end
    in_valid <= 0;
    allow_stall = 0;
    wait_cnt = 0;
    while (angles_due.size() != 0 && wait_cnt < 100000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && angles_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
